/* rtl/gha_pkg.sv */
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants for the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

   localparam int MAX_HANDLES = 1024;
   localparam int GEN_BITS    = 16;
   localparam int IDX_W       = $clog2(MAX_HANDLES);
   localparam int CNT_W       = $clog2(MAX_HANDLES + 1);
   localparam int ENTRY_W     = GEN_BITS + 1;

   typedef enum logic [1:0] {
      ACT_CREATE,
      ACT_DESTROY,
      ACT_CHECK,
      ACT_READ_GEN
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_FULL,
      STATUS_INVALID
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_LOOKUP,
      S_EXEC
   } state_type;

   // Generation table entry: live flag plus current generation
   typedef struct packed {
      logic                live;
      logic [GEN_BITS-1:0] gen;
   } entry_type;

   typedef struct packed {
      logic load_req;
      logic latch_slot;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic pop_needed;
   } stat_type;

endpackage

/* rtl/gha_ram.sv */
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/gha_ctrl.sv */
// ----------------------------------------------------------------------------
// gha_ctrl
// Sequencer: accept a request, pop the free stack if needed, look up the
// generation table, then commit the result into the output register.
// ----------------------------------------------------------------------------
module gha_ctrl
   import gha_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type dp_stat,
   output cmd_type  dp_cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = dp_stat.pop_needed ? S_POP : S_LOOKUP;
            end
         end
         S_POP:    state_in = S_LOOKUP;
         S_LOOKUP: state_in = S_EXEC;
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd    = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall       = 1'b0;
            dp_cmd.load_req = req_valid;
         end
         S_POP:    ;
         S_LOOKUP: dp_cmd.latch_slot = 1'b1;
         S_EXEC:   dp_cmd.commit = out_free;
         default:  ;
      endcase
   end

   // Hold the beat while stalled, drop it once taken
   always_comb begin
      if (dp_cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/gha_dpath.sv */
// ----------------------------------------------------------------------------
// gha_dpath
// Request registers, counters, free stack and generation table memories,
// update logic and the result register.
// ----------------------------------------------------------------------------
module gha_dpath
   import gha_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          req_action,
   input  logic [IDX_W-1:0]    req_entity_index,
   input  logic [GEN_BITS-1:0] req_handle_generation,
   input  cmd_type             dp_cmd,
   output stat_type            dp_stat,
   output logic [1:0]          rsp_status,
   output logic [IDX_W-1:0]    rsp_result_index,
   output logic [GEN_BITS-1:0] rsp_result_generation,
   output logic                rsp_is_live,
   output logic [CNT_W-1:0]    rsp_live_count
);

   action_type          act_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [GEN_BITS-1:0] hgen_ff;
   logic [IDX_W-1:0]    slot_ff, slot_sel;
   logic [CNT_W-1:0]    depth_ff, depth_in;
   logic [CNT_W-1:0]    fresh_ff, fresh_in;
   logic [CNT_W-1:0]    live_ff, live_in;

   logic [IDX_W-1:0]    stk_rd_addr, stk_rdata;
   logic                stk_we;
   logic [IDX_W-1:0]    tbl_rd_addr;
   logic                tbl_we;
   entry_type           tbl_rdata, tbl_wdata, entry;

   status_type          status_n;
   logic [IDX_W-1:0]    r_idx;
   logic [GEN_BITS-1:0] r_gen;
   logic                r_live;
   logic                match;

   logic [1:0]          status_ff;
   logic [IDX_W-1:0]    r_idx_ff;
   logic [GEN_BITS-1:0] r_gen_ff;
   logic                r_live_ff;
   logic [CNT_W-1:0]    r_count_ff;

   assign dp_stat.pop_needed = (action_type'(req_action) == ACT_CREATE) && (depth_ff != '0);

   // Top of stack sits at depth - 1
   assign stk_rd_addr = IDX_W'(depth_ff - CNT_W'(1));

   always_comb begin
      if (act_ff == ACT_CREATE) begin
         slot_sel = (depth_ff != '0) ? stk_rdata : fresh_ff[IDX_W-1:0];
      end else begin
         slot_sel = idx_ff;
      end
   end

   assign tbl_rd_addr = dp_cmd.latch_slot ? slot_sel : slot_ff;

   // Entries at or above next_fresh were never written: read them as zero
   assign entry = ({1'b0, slot_ff} < fresh_ff) ? tbl_rdata : '0;
   assign match = entry.live && (entry.gen == hgen_ff);

   always_comb begin
      tbl_we    = 1'b0;
      stk_we    = 1'b0;
      tbl_wdata = entry;
      depth_in  = depth_ff;
      fresh_in  = fresh_ff;
      live_in   = live_ff;
      status_n  = STATUS_OK;
      r_idx     = idx_ff;
      r_gen     = entry.gen;
      r_live    = 1'b0;
      case (act_ff)
         ACT_CREATE: begin
            if (depth_ff != '0 || fresh_ff < CNT_W'(MAX_HANDLES)) begin
               if (depth_ff != '0) begin
                  depth_in = depth_ff - CNT_W'(1);
               end else begin
                  fresh_in = fresh_ff + CNT_W'(1);
               end
               tbl_we         = 1'b1;
               tbl_wdata.live = 1'b1;
               live_in        = live_ff + CNT_W'(1);
               r_idx          = slot_ff;
               r_live         = 1'b1;
            end else begin
               status_n = STATUS_FULL;
               r_gen    = '0;
            end
         end
         ACT_DESTROY: begin
            if (match && depth_ff < CNT_W'(MAX_HANDLES)) begin
               tbl_we         = 1'b1;
               tbl_wdata.live = 1'b0;
               tbl_wdata.gen  = entry.gen + GEN_BITS'(1);
               stk_we         = 1'b1;
               depth_in       = depth_ff + CNT_W'(1);
               if (live_ff != '0) begin
                  live_in = live_ff - CNT_W'(1);
               end
               r_gen  = tbl_wdata.gen;
               r_live = 1'b1;
            end else begin
               status_n = STATUS_INVALID;
            end
         end
         ACT_CHECK: r_live = match;
         default:   ;
      endcase
   end

   gha_ram #(
      .WIDTH (IDX_W),
      .DEPTH (MAX_HANDLES)
   ) u_free_stack (
      .clock   (clock),
      .wr_en   (stk_we && dp_cmd.commit),
      .wr_addr (depth_ff[IDX_W-1:0]),
      .wr_data (idx_ff),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rdata)
   );

   gha_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_HANDLES)
   ) u_gen_table (
      .clock   (clock),
      .wr_en   (tbl_we && dp_cmd.commit),
      .wr_addr (slot_ff),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         fresh_ff <= '0;
         live_ff  <= '0;
      end else if (dp_cmd.commit) begin
         depth_ff <= depth_in;
         fresh_ff <= fresh_in;
         live_ff  <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_req) begin
         act_ff  <= action_type'(req_action);
         idx_ff  <= req_entity_index;
         hgen_ff <= req_handle_generation;
      end
      if (dp_cmd.latch_slot) begin
         slot_ff <= slot_sel;
      end
      if (dp_cmd.commit) begin
         status_ff  <= status_n;
         r_idx_ff   <= r_idx;
         r_gen_ff   <= r_gen;
         r_live_ff  <= r_live;
         r_count_ff <= live_in;
      end
   end

   assign rsp_status            = status_ff;
   assign rsp_result_index      = r_idx_ff;
   assign rsp_result_generation = r_gen_ff;
   assign rsp_is_live           = r_live_ff;
   assign rsp_live_count        = r_count_ff;

endmodule

/* rtl/generational_handle_allocator.sv */
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Allocates index+generation handles from a LIFO free list or fresh indices,
// validates and frees handles, and answers generation queries.
// ----------------------------------------------------------------------------
//   channel   direction   handshake              payload
//   req       in          req_valid/req_stall    action, entity_index,
//                                                handle_generation
//   rsp       out         rsp_valid/rsp_stall    status, result_index,
//                                                result_generation, is_live,
//                                                live_count
//
// One item at a time: each item passes through the idle, lookup and exec states,
// and a create served from the free stack also through a pop state for the stack
// read ahead of the generation table read, both through registered-read RAMs.
// The result sits in an output register; a stalled result holds the next item
// in its exec state until the result is taken.
// Reset clears the counters only; no clearing pass is run. Indices at or
// above the fresh-index count read as generation zero, not live.
// ----------------------------------------------------------------------------
module generational_handle_allocator
   import gha_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic [IDX_W-1:0]    req_entity_index,
   input  logic [GEN_BITS-1:0] req_handle_generation,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [IDX_W-1:0]    rsp_result_index,
   output logic [GEN_BITS-1:0] rsp_result_generation,
   output logic                rsp_is_live,
   output logic [CNT_W-1:0]    rsp_live_count
);

   cmd_type  dp_cmd;
   stat_type dp_stat;

   gha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   gha_dpath u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .req_action            (req_action),
      .req_entity_index      (req_entity_index),
      .req_handle_generation (req_handle_generation),
      .dp_cmd                (dp_cmd),
      .dp_stat               (dp_stat),
      .rsp_status            (rsp_status),
      .rsp_result_index      (rsp_result_index),
      .rsp_result_generation (rsp_result_generation),
      .rsp_is_live           (rsp_is_live),
      .rsp_live_count        (rsp_live_count)
   );

   a_accept_no_commit: assert property (@(posedge clock) disable iff (reset)
      !(dp_cmd.load_req && dp_cmd.commit))
      else $error("request accepted while a result commits");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.commit |=> rsp_valid)
      else $error("committed result not presented");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_live_count <= CNT_W'(MAX_HANDLES)))
      else $error("live count out of range");

   a_full_not_live: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |-> !rsp_is_live)
      else $error("full create reported live");

endmodule

/* sim/tb_generational_handle_allocator.sv */
// ----------------------------------------------------------------------------
// tb_generational_handle_allocator
// Self-checking bench for the generational handle allocator. A typed table
// covers reset state, extremes, invalid and stale handles and LIFO reuse.
// Random traffic follows: mixed, a create-heavy build-up and a destroy-heavy
// drain. Untyped responses are checked against an in-bench allocator copy.
// ----------------------------------------------------------------------------
module tb_generational_handle_allocator;
   import gha_pkg::*;

   localparam int STALL_LIMIT    = 3000;
   localparam int BACKLOG_CYCLES = 300;
   localparam int ROWS           = 22;

   typedef struct packed {
      action_type          action;
      logic [IDX_W-1:0]    index;
      logic [GEN_BITS-1:0] gen;
   } request_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [IDX_W-1:0]    index;
      logic [GEN_BITS-1:0] gen;
      logic                live;
      logic [CNT_W-1:0]    count;
   } outcome_type;

   typedef struct packed {
      action_type          action;
      logic [IDX_W-1:0]    index;
      logic [GEN_BITS-1:0] gen;
      logic                typed;
      outcome_type         outcome;
   } row_type;

   // action, index, generation, typed, expected {status, index, gen, live, count}
   localparam row_type DIRECTED_ROWS [ROWS] = '{
      '{ACT_READ_GEN, 10'd0,    16'h0000, 1'b1, '{STATUS_OK,      10'd0,    16'd0, 1'b0, 11'd0}},
      '{ACT_CHECK,    10'd1023, 16'h0000, 1'b1, '{STATUS_OK,      10'd1023, 16'd0, 1'b0, 11'd0}},
      '{ACT_DESTROY,  10'd1023, 16'hFFFF, 1'b1, '{STATUS_INVALID, 10'd1023, 16'd0, 1'b0, 11'd0}},
      '{ACT_CREATE,   10'd1023, 16'hFFFF, 1'b1, '{STATUS_OK,      10'd0,    16'd0, 1'b1, 11'd1}},
      '{ACT_CREATE,   10'd0,    16'h0000, 1'b1, '{STATUS_OK,      10'd1,    16'd0, 1'b1, 11'd2}},
      '{ACT_CHECK,    10'd0,    16'h0000, 1'b1, '{STATUS_OK,      10'd0,    16'd0, 1'b1, 11'd2}},
      '{ACT_CHECK,    10'd0,    16'h0001, 1'b1, '{STATUS_OK,      10'd0,    16'd0, 1'b0, 11'd2}},
      '{ACT_DESTROY,  10'd0,    16'h0000, 1'b1, '{STATUS_OK,      10'd0,    16'd1, 1'b1, 11'd1}},
      '{ACT_DESTROY,  10'd0,    16'h0000, 1'b1, '{STATUS_INVALID, 10'd0,    16'd1, 1'b0, 11'd1}},
      '{ACT_DESTROY,  10'd0,    16'h0001, 1'b1, '{STATUS_INVALID, 10'd0,    16'd1, 1'b0, 11'd1}},
      '{ACT_CHECK,    10'd0,    16'h0001, 1'b1, '{STATUS_OK,      10'd0,    16'd1, 1'b0, 11'd1}},
      '{ACT_CREATE,   10'd0,    16'h0000, 1'b1, '{STATUS_OK,      10'd0,    16'd1, 1'b1, 11'd2}},
      '{ACT_CHECK,    10'd0,    16'h0001, 1'b1, '{STATUS_OK,      10'd0,    16'd1, 1'b1, 11'd2}},
      '{ACT_READ_GEN, 10'd0,    16'hFFFF, 1'b1, '{STATUS_OK,      10'd0,    16'd1, 1'b0, 11'd2}},
      '{ACT_DESTROY,  10'd1,    16'h0000, 1'b1, '{STATUS_OK,      10'd1,    16'd1, 1'b1, 11'd1}},
      '{ACT_DESTROY,  10'd0,    16'h0001, 1'b1, '{STATUS_OK,      10'd0,    16'd2, 1'b1, 11'd0}},
      '{ACT_CREATE,   10'd0,    16'h0000, 1'b0, '0},
      '{ACT_CREATE,   10'd0,    16'h0000, 1'b0, '0},
      '{ACT_CREATE,   10'd0,    16'h0000, 1'b0, '0},
      '{ACT_READ_GEN, 10'd1023, 16'hFFFF, 1'b1, '{STATUS_OK,      10'd1023, 16'd0, 1'b0, 11'd3}},
      '{ACT_CHECK,    10'd2,    16'hFFFF, 1'b1, '{STATUS_OK,      10'd2,    16'd0, 1'b0, 11'd3}},
      '{ACT_DESTROY,  10'd2,    16'h0000, 1'b1, '{STATUS_OK,      10'd2,    16'd1, 1'b1, 11'd2}}
   };

   logic                clock                 = 1'b0;
   logic                reset                 = 1'b1;
   logic                req_valid             = 1'b0;
   logic                req_stall;
   logic [1:0]          req_action            = '0;
   logic [IDX_W-1:0]    req_entity_index      = '0;
   logic [GEN_BITS-1:0] req_handle_generation = '0;
   logic                rsp_valid;
   logic                rsp_stall             = 1'b0;
   logic [1:0]          rsp_status;
   logic [IDX_W-1:0]    rsp_result_index;
   logic [GEN_BITS-1:0] rsp_result_generation;
   logic                rsp_is_live;
   logic [CNT_W-1:0]    rsp_live_count;

   // allocator copy
   bit [GEN_BITS-1:0] gen_table [MAX_HANDLES];
   bit                live_flag [MAX_HANDLES];
   bit [IDX_W-1:0]    free_slots [MAX_HANDLES];
   int                free_top   = 0;
   int                fresh_next = 0;
   int                live_total = 0;
   logic [IDX_W-1:0]  live_list [$];

   outcome_type owed_outcomes [$];
   int          mismatch_count = 0;
   int          results_seen   = 0;
   bit          calm           = 1'b0;
   bit          backlog_done   = 1'b0;

   generational_handle_allocator u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_entity_index      (req_entity_index),
      .req_handle_generation (req_handle_generation),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_result_index      (rsp_result_index),
      .rsp_result_generation (rsp_result_generation),
      .rsp_is_live           (rsp_is_live),
      .rsp_live_count        (rsp_live_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 40) $display("ERROR @%0t: %s", $time, what);
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   function automatic int idle_cycles();
      if (calm) return 0;
      return $urandom_range(0, 19);
   endfunction

   // Apply one request to the allocator copy and return its response.
   function automatic outcome_type run_allocator(input request_type q);
      outcome_type      r;
      logic [IDX_W-1:0] slot;
      bit               got_slot;
      r.status = STATUS_OK;
      r.index  = q.index;
      r.gen    = '0;
      r.live   = 1'b0;
      slot     = '0;
      got_slot = 1'b0;
      case (q.action)
         ACT_CREATE: begin
            if (free_top > 0) begin
               free_top--;
               slot     = free_slots[free_top];
               got_slot = 1'b1;
            end else if (fresh_next < MAX_HANDLES) begin
               slot     = IDX_W'(fresh_next);
               fresh_next++;
               got_slot = 1'b1;
            end
            if (got_slot) begin
               live_flag[slot] = 1'b1;
               live_total++;
               live_list.insert(live_list.size(), slot);
               r.index = slot;
               r.gen   = gen_table[slot];
               r.live  = 1'b1;
            end else begin
               r.status = STATUS_FULL;
            end
         end
         ACT_DESTROY: begin
            if (live_flag[q.index] && gen_table[q.index] == q.gen) begin
               live_flag[q.index]   = 1'b0;
               gen_table[q.index]   = gen_table[q.index] + 1'b1;
               free_slots[free_top] = q.index;
               free_top++;
               live_total--;
               foreach (live_list[k]) begin
                  if (live_list[k] == q.index) begin
                     live_list.delete(k);
                     break;
                  end
               end
               r.live = 1'b1;
            end else begin
               r.status = STATUS_INVALID;
            end
            r.gen = gen_table[q.index];
         end
         ACT_CHECK: begin
            r.live = live_flag[q.index] && gen_table[q.index] == q.gen;
            r.gen  = gen_table[q.index];
         end
         default: r.gen = gen_table[q.index];
      endcase
      r.count = CNT_W'(live_total);
      return r;
   endfunction

   // Mostly well-formed traffic: creates, destroys of live handles, and
   // touches on used indices with a current or one-behind generation.
   function automatic request_type pick_request(input int create_w, input int kill_w);
      request_type q;
      int          roll;
      roll     = $urandom_range(0, 99);
      q.action = action_type'($urandom_range(0, 3));
      q.index  = IDX_W'($urandom_range(0, MAX_HANDLES - 1));
      q.gen    = GEN_BITS'($urandom_range(0, 16'hFFFF));
      if (roll < create_w) begin
         q.action = ACT_CREATE;
      end else if (roll < create_w + kill_w && live_list.size() > 0) begin
         q.action = ACT_DESTROY;
         q.index  = live_list[$urandom_range(0, live_list.size() - 1)];
         q.gen    = gen_table[q.index];
      end else if (roll < 90 && fresh_next > 0) begin
         q.action = action_type'($urandom_range(1, 3));
         q.index  = IDX_W'($urandom_range(0, fresh_next - 1));
         q.gen    = gen_table[q.index] - GEN_BITS'($urandom_range(0, 1));
      end
      return q;
   endfunction

   task automatic offer_request(input request_type q);
      int gap;
      if ($urandom_range(0, 39) == 0) calm = ($urandom_range(0, 3) == 0);
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_action            <= q.action;
      req_entity_index      <= q.index;
      req_handle_generation <= q.gen;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic issue(input request_type q, output outcome_type want);
      offer_request(q);
      want = run_allocator(q);
      owed_outcomes.insert(owed_outcomes.size(), want);
   endtask

   initial begin : stimulus
      outcome_type want;
      request_type q;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         q = '{DIRECTED_ROWS[i].action, DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].gen};
         offer_request(q);
         want = run_allocator(q);
         owed_outcomes.insert(owed_outcomes.size(),
                              DIRECTED_ROWS[i].typed ? DIRECTED_ROWS[i].outcome : want);
      end

      repeat (300) issue(pick_request(30, 30), want);

      // build up live handles, then drain most of them
      repeat (250) issue(pick_request(70, 10), want);
      repeat (130) issue(pick_request(10, 70), want);

      req_valid <= 1'b0;
      while (owed_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin : response_side
      int hold;
      wait (!reset);
      forever begin
         hold = idle_cycles();
         // hold off once long enough for the block to back up into its input
         if (!backlog_done && results_seen >= 60) begin
            hold         = BACKLOG_CYCLES;
            backlog_done = 1'b1;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin : response_check
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (owed_outcomes.size() == 0) begin
            report_mismatch("response beat with no request outstanding");
         end else begin
            want = owed_outcomes.pop_front();
            compare_field("status", 16'(rsp_status), 16'(want.status));
            compare_field("result_index", 16'(rsp_result_index), 16'(want.index));
            compare_field("result_generation", rsp_result_generation, want.gen);
            compare_field("is_live", 16'(rsp_is_live), 16'(want.live));
            compare_field("live_count", 16'(rsp_live_count), 16'(want.count));
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
